### hw/rtl/i2cm_pkg.sv
// shared types and constants for the i2c master byte engine
package i2cm_pkg;

  localparam int DIV_WIDTH = 16;
  localparam int PH_W      = 5;

  // command codes carried in the kind field
  localparam logic [2:0] KIND_TICK  = 3'd0;
  localparam logic [2:0] KIND_START = 3'd1;
  localparam logic [2:0] KIND_STOP  = 3'd2;
  localparam logic [2:0] KIND_WRITE = 3'd3;
  localparam logic [2:0] KIND_READ  = 3'd4;

  // phases per command
  localparam logic [PH_W-1:0] START_PHASES = PH_W'(3);
  localparam logic [PH_W-1:0] STOP_PHASES  = PH_W'(1);
  localparam logic [PH_W-1:0] WRITE_PHASES = PH_W'(27);
  localparam logic [PH_W-1:0] READ_PHASES  = PH_W'(20);

  // write sequence landmarks
  localparam logic [PH_W-1:0] WR_ACK_LOW    = PH_W'(24);
  localparam logic [PH_W-1:0] WR_ACK_HIGH   = PH_W'(25);
  localparam logic [PH_W-1:0] WR_ACK_END    = PH_W'(26);
  // read sequence landmarks
  localparam logic [PH_W-1:0] RD_ACK_LOW    = PH_W'(16);
  localparam logic [PH_W-1:0] RD_ACK_DRIVE  = PH_W'(17);
  localparam logic [PH_W-1:0] RD_ACK_HIGH   = PH_W'(18);

  localparam logic [DIV_WIDTH-1:0] QUANTUM_RESET = DIV_WIDTH'(250);

  typedef enum logic [4:0] {
    CMD_IDLE  = 5'b00001,
    CMD_START = 5'b00010,
    CMD_STOP  = 5'b00100,
    CMD_WRITE = 5'b01000,
    CMD_READ  = 5'b10000
  } cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] tx_byte;
    logic       ack_to_send;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_received;
    logic       cmd_rejected;
  } out_item_t;

endpackage

### hw/rtl/i2c_master_byte_engine.sv
// i2c master byte engine: bus sequencer with one tick per beat and a skid output
//
// Each input beat is one tick of the bus sequencer and produces exactly one
// result beat. A beat with a command kind (start, stop, write byte, read byte)
// starts that command when the engine is idle; while a command runs, further
// commands are dropped and flagged by cmd_rejected. A command is a fixed list
// of phases, each lasting quantum_ticks input beats (0 acts as 1); start has
// 3 phases, stop 1, write 27 and read 20. scl_out and sda_out give the
// open-drain line levels (1 = released), done_res pulses on the beat in which
// a command finishes. Throughput is one beat per clock: the sequencer state is
// updated in the accepting cycle by a short compare/increment path, and the
// result lands in an output register backed by a one-entry skid register, so
// in_stall rises only when both are full. quantum_ticks is written through the cfg port, which is
// always ready, and must only be written while no command is running.
module i2c_master_byte_engine
  import i2cm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [DIV_WIDTH-1:0] cfg_data
);

  // configuration
  logic [DIV_WIDTH-1:0] quantum_r;

  // sequencer state
  cmd_t                 cmd_r, cmd_nxt;
  logic [PH_W-1:0]      ph_r, ph_nxt;
  logic [1:0]           sub_r, sub_nxt;     // position within a write bit
  logic [DIV_WIDTH-1:0] cnt_r, cnt_nxt;
  logic [7:0]           shift_r, shift_nxt;
  logic                 reply_r, reply_nxt;
  logic                 scl_r, scl_nxt;
  logic                 sda_r, sda_nxt;
  logic                 sack_r, sack_nxt;
  logic [7:0]           last_rd_r, last_rd_nxt;

  // output register and skid
  out_item_t            main_r, skid_r;
  logic                 main_vld_r, skid_vld_r;

  out_item_t            res;
  logic                 in_fire, out_fire;
  logic                 is_cmd, done, rejected;
  cmd_t                 kind_cmd;
  logic [DIV_WIDTH-1:0] q_eff;
  logic [DIV_WIDTH:0]   cnt_inc;
  logic                 ph_end;
  logic [PH_W-1:0]      ph_inc, ph_total;
  logic [1:0]           sub_inc;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_vld_r;
  assign in_fire   = in_valid & ~skid_vld_r;
  assign out_fire  = main_vld_r & ~out_stall;
  assign out_valid = main_vld_r;
  assign out_data  = main_r;

  // decode the command kind, unknown kinds behave as plain ticks
  always_comb begin
    unique case (in_data.kind)
      KIND_START: kind_cmd = CMD_START;
      KIND_STOP:  kind_cmd = CMD_STOP;
      KIND_WRITE: kind_cmd = CMD_WRITE;
      KIND_READ:  kind_cmd = CMD_READ;
      default:    kind_cmd = CMD_IDLE;
    endcase
  end
  assign is_cmd = (kind_cmd != CMD_IDLE);

  // phase timing: a zero quantum counts as one
  assign q_eff   = (quantum_r == '0) ? DIV_WIDTH'(1) : quantum_r;
  assign cnt_inc = {1'b0, cnt_r} + (DIV_WIDTH+1)'(1);
  assign ph_end  = (cnt_inc >= {1'b0, q_eff});
  assign ph_inc  = ph_r + PH_W'(1);
  assign sub_inc = (sub_r == 2'd2) ? 2'd0 : sub_r + 2'd1;

  always_comb begin
    unique case (cmd_r)
      CMD_START: ph_total = START_PHASES;
      CMD_STOP:  ph_total = STOP_PHASES;
      CMD_WRITE: ph_total = WRITE_PHASES;
      CMD_READ:  ph_total = READ_PHASES;
      default:   ph_total = '0;
    endcase
  end

  // sequencer next state
  always_comb begin
    cmd_nxt     = cmd_r;
    ph_nxt      = ph_r;
    sub_nxt     = sub_r;
    cnt_nxt     = cnt_r;
    shift_nxt   = shift_r;
    reply_nxt   = reply_r;
    scl_nxt     = scl_r;
    sda_nxt     = sda_r;
    sack_nxt    = sack_r;
    last_rd_nxt = last_rd_r;
    done        = 1'b0;
    rejected    = 1'b0;

    if (cmd_r != CMD_IDLE) begin
      rejected = is_cmd;
      if (ph_end) begin
        cnt_nxt = '0;
        // sampling at the end of the phase that is closing
        if (cmd_r == CMD_WRITE && ph_r == WR_ACK_HIGH) begin
          sack_nxt = in_data.sda_in;
        end else if (cmd_r == CMD_READ && ph_r < RD_ACK_LOW && ph_r[0]) begin
          shift_nxt = {shift_r[6:0], in_data.sda_in};
        end
        if (ph_inc >= ph_total) begin
          if (cmd_r == CMD_STOP) sda_nxt = 1'b1;
          if (cmd_r == CMD_READ) last_rd_nxt = shift_nxt;
          cmd_nxt = CMD_IDLE;
          ph_nxt  = '0;
          done    = 1'b1;
        end else begin
          ph_nxt  = ph_inc;
          sub_nxt = sub_inc;
          // pin actions on entering the next phase
          unique case (cmd_r)
            CMD_START: begin
              if (ph_inc == PH_W'(1)) sda_nxt = 1'b0;
              else scl_nxt = 1'b0;
            end
            CMD_WRITE: begin
              if (ph_inc < WR_ACK_LOW) begin
                case (sub_inc)
                  2'd0: scl_nxt = 1'b0;
                  2'd1: begin
                    sda_nxt   = shift_r[7];
                    shift_nxt = {shift_r[6:0], 1'b0};
                  end
                  default: scl_nxt = 1'b1;
                endcase
              end else if (ph_inc == WR_ACK_LOW) begin
                scl_nxt = 1'b0;
                sda_nxt = 1'b1;
              end else if (ph_inc == WR_ACK_HIGH) begin
                scl_nxt = 1'b1;
              end else begin
                scl_nxt = 1'b0;
              end
            end
            CMD_READ: begin
              if (ph_inc < RD_ACK_LOW) begin
                scl_nxt = ph_inc[0];
              end else if (ph_inc == RD_ACK_LOW) begin
                scl_nxt = 1'b0;
              end else if (ph_inc == RD_ACK_DRIVE) begin
                sda_nxt = reply_r;
              end else if (ph_inc == RD_ACK_HIGH) begin
                scl_nxt = 1'b1;
              end else begin
                scl_nxt = 1'b0;
                sda_nxt = 1'b1;
              end
            end
            default: begin
              sda_nxt = 1'b0;
              scl_nxt = 1'b1;
            end
          endcase
        end
      end else begin
        cnt_nxt = cnt_inc[DIV_WIDTH-1:0];
      end
    end else if (is_cmd) begin
      cmd_nxt = kind_cmd;
      ph_nxt  = '0;
      sub_nxt = 2'd0;
      cnt_nxt = '0;
      // phase 0 pin actions
      unique case (kind_cmd)
        CMD_START: begin
          sda_nxt = 1'b1;
          scl_nxt = 1'b1;
        end
        CMD_STOP: begin
          sda_nxt = 1'b0;
          scl_nxt = 1'b1;
        end
        CMD_WRITE: begin
          shift_nxt = in_data.tx_byte;
          scl_nxt   = 1'b0;
        end
        CMD_READ: begin
          shift_nxt = 8'd0;
          reply_nxt = in_data.ack_to_send;
          scl_nxt   = 1'b0;
        end
        default: begin
          scl_nxt = scl_r;
        end
      endcase
    end
  end

  // result of this beat
  always_comb begin
    res.scl_out      = scl_nxt;
    res.sda_out      = sda_nxt;
    res.busy_res     = (cmd_nxt != CMD_IDLE);
    res.done_res     = done;
    res.rx_byte      = last_rd_nxt;
    res.ack_received = sack_nxt;
    res.cmd_rejected = rejected;
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quantum_r <= QUANTUM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      quantum_r <= cfg_data;
    end
  end

  // sequencer registers, advanced once per accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r     <= CMD_IDLE;
      ph_r      <= '0;
      sub_r     <= 2'd0;
      cnt_r     <= '0;
      shift_r   <= 8'd0;
      reply_r   <= 1'b0;
      scl_r     <= 1'b1;
      sda_r     <= 1'b1;
      sack_r    <= 1'b0;
      last_rd_r <= 8'd0;
    end else if (in_fire) begin
      cmd_r     <= cmd_nxt;
      ph_r      <= ph_nxt;
      sub_r     <= sub_nxt;
      cnt_r     <= cnt_nxt;
      shift_r   <= shift_nxt;
      reply_r   <= reply_nxt;
      scl_r     <= scl_nxt;
      sda_r     <= sda_nxt;
      sack_r    <= sack_nxt;
      last_rd_r <= last_rd_nxt;
    end
  end

  // output control: main register plus one skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (out_fire || !main_vld_r) begin
      if (skid_vld_r) begin
        skid_vld_r <= 1'b0;
        main_vld_r <= 1'b1;
      end else begin
        main_vld_r <= in_fire;
      end
    end else if (in_fire) begin
      skid_vld_r <= 1'b1;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (out_fire || !main_vld_r) begin
      if (skid_vld_r) begin
        main_r <= skid_r;
      end else if (in_fire) begin
        main_r <= res;
      end
    end else if (in_fire) begin
      skid_r <= res;
    end
  end

endmodule

### bench/i2c_master_byte_engine_tb.sv
// self-checking testbench for the i2c master byte engine: line-level tracker and checks
`timescale 1ns / 1ps

module i2c_master_byte_engine_tb
  import i2cm_pkg::*;
();

  // tracks the bus sequencer beat by beat and holds the line levels still due
  class i2c_line_tracker;
    logic [DIV_WIDTH-1:0] quantum;
    cmd_t                 active;
    logic [PH_W-1:0]      phase;
    logic [DIV_WIDTH:0]   ticks;
    logic [7:0]           shift_reg;
    logic [7:0]           last_rx;
    logic                 reply_ack;
    logic                 scl;
    logic                 sda;
    logic                 slave_ack;
    out_item_t            levels_due[$];
    int                   errors;
    int                   results_seen;

    function new();
      quantum      = QUANTUM_RESET;
      active       = CMD_IDLE;
      phase        = '0;
      ticks        = '0;
      shift_reg    = '0;
      last_rx      = '0;
      reply_ack    = 1'b0;
      scl          = 1'b1;
      sda          = 1'b1;
      slave_ack    = 1'b0;
      errors       = 0;
      results_seen = 0;
    endfunction

    function void set_quantum(logic [DIV_WIDTH-1:0] value);
      quantum = value;
    endfunction

    function bit busy();
      return active != CMD_IDLE;
    endfunction

    function int pending();
      return levels_due.size();
    endfunction

    function cmd_t kind_cmd(logic [2:0] kind);
      case (kind)
        KIND_START: return CMD_START;
        KIND_STOP:  return CMD_STOP;
        KIND_WRITE: return CMD_WRITE;
        KIND_READ:  return CMD_READ;
        default:    return CMD_IDLE;
      endcase
    endfunction

    function logic [PH_W-1:0] phases_of(cmd_t c);
      case (c)
        CMD_START: return START_PHASES;
        CMD_STOP:  return STOP_PHASES;
        CMD_WRITE: return WRITE_PHASES;
        CMD_READ:  return READ_PHASES;
        default:   return '0;
      endcase
    endfunction

    // pin actions at the head of a phase
    function void enter_phase(logic [PH_W-1:0] ph);
      case (active)
        CMD_START: begin
          if (ph == 0) begin
            sda = 1'b1;
            scl = 1'b1;
          end else if (ph == 1) begin
            sda = 1'b0;
          end else begin
            scl = 1'b0;
          end
        end
        CMD_STOP: begin
          sda = 1'b0;
          scl = 1'b1;
        end
        CMD_WRITE: begin
          if (ph < WR_ACK_LOW) begin
            case (ph % 3)
              0:       scl = 1'b0;
              1:       sda = shift_reg[7 - ph / 3];
              default: scl = 1'b1;
            endcase
          end else if (ph == WR_ACK_LOW) begin
            scl = 1'b0;
            sda = 1'b1;
          end else if (ph == WR_ACK_HIGH) begin
            scl = 1'b1;
          end else begin
            scl = 1'b0;
          end
        end
        CMD_READ: begin
          if (ph < RD_ACK_LOW) begin
            scl = ph[0];
          end else if (ph == RD_ACK_LOW) begin
            scl = 1'b0;
          end else if (ph == RD_ACK_DRIVE) begin
            sda = reply_ack;
          end else if (ph == RD_ACK_HIGH) begin
            scl = 1'b1;
          end else begin
            scl = 1'b0;
            sda = 1'b1;
          end
        end
        default: ;
      endcase
    endfunction

    // works out the levels after one accepted tick and queues them
    function void note_tick(in_item_t it);
      out_item_t          want;
      logic               is_cmd;
      logic               done;
      logic               rejected;
      logic [DIV_WIDTH:0] eff;
      is_cmd   = (it.kind >= KIND_START) && (it.kind <= KIND_READ);
      eff      = (quantum == '0) ? (DIV_WIDTH+1)'(1) : {1'b0, quantum};
      done     = 1'b0;
      rejected = 1'b0;
      if (active != CMD_IDLE) begin
        if (is_cmd) rejected = 1'b1;
        ticks = ticks + (DIV_WIDTH+1)'(1);
        if (ticks >= eff) begin
          ticks = '0;
          // sampling at the end of the phase
          if (active == CMD_WRITE && phase == WR_ACK_HIGH) begin
            slave_ack = it.sda_in;
          end else if (active == CMD_READ && phase < RD_ACK_LOW && phase[0]) begin
            shift_reg = {shift_reg[6:0], it.sda_in};
          end
          phase = phase + PH_W'(1);
          if (phase >= phases_of(active)) begin
            if (active == CMD_STOP) sda = 1'b1;
            if (active == CMD_READ) last_rx = shift_reg;
            active = CMD_IDLE;
            phase  = '0;
            done   = 1'b1;
          end else begin
            enter_phase(phase);
          end
        end
      end else if (is_cmd) begin
        active = kind_cmd(it.kind);
        phase  = '0;
        ticks  = '0;
        if (active == CMD_WRITE) begin
          shift_reg = it.tx_byte;
        end else if (active == CMD_READ) begin
          shift_reg = '0;
          reply_ack = it.ack_to_send;
        end
        enter_phase(phase);
      end
      want.scl_out      = scl;
      want.sda_out      = sda;
      want.busy_res     = (active != CMD_IDLE);
      want.done_res     = done;
      want.rx_byte      = last_rx;
      want.ack_received = slave_ack;
      want.cmd_rejected = rejected;
      levels_due.push_back(want);
    endfunction

    task report_mismatch(string what, logic [7:0] got, logic [7:0] want);
      if (errors < 40) begin
        $display("[%0t] result %0d: %s is %h, want %h", $time, results_seen, what, got, want);
      end
      errors++;
    endtask

    task check_levels(out_item_t got);
      out_item_t want;
      if (levels_due.size() == 0) begin
        report_mismatch("beat with nothing due", 8'(got), 8'h00);
      end else begin
        want = levels_due.pop_front();
        if (got.scl_out !== want.scl_out)
          report_mismatch("scl_out", 8'(got.scl_out), 8'(want.scl_out));
        if (got.sda_out !== want.sda_out)
          report_mismatch("sda_out", 8'(got.sda_out), 8'(want.sda_out));
        if (got.busy_res !== want.busy_res)
          report_mismatch("busy_res", 8'(got.busy_res), 8'(want.busy_res));
        if (got.done_res !== want.done_res)
          report_mismatch("done_res", 8'(got.done_res), 8'(want.done_res));
        if (got.rx_byte !== want.rx_byte) report_mismatch("rx_byte", got.rx_byte, want.rx_byte);
        if (got.ack_received !== want.ack_received)
          report_mismatch("ack_received", 8'(got.ack_received), 8'(want.ack_received));
        if (got.cmd_rejected !== want.cmd_rejected)
          report_mismatch("cmd_rejected", 8'(got.cmd_rejected), 8'(want.cmd_rejected));
      end
      results_seen++;
    endtask
  endclass

  // cycles with no beat moving on any port before the run is given up
  localparam int STALL_LIMIT = 3000;
  // length of the one long receiver hold-off
  localparam int HOLD_CYCLES = 120;
  // random ticks per quantum setting
  localparam int RANDOM_BEATS = 80;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_item_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [DIV_WIDTH-1:0] cfg_data;

  i2c_line_tracker tracker = new();

  // sender burst bookkeeping and the hold-off handshake between processes
  int burst_left  = 0;
  bit hold_req    = 1'b0;
  bit hold_active = 1'b0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  i2c_master_byte_engine u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // builds one tick beat from its fields
  function automatic in_item_t tick_of(logic [2:0] kind, logic [7:0] tx, logic ack, logic sda);
    in_item_t it;
    it.kind        = kind;
    it.tx_byte     = tx;
    it.ack_to_send = ack;
    it.sda_in      = sda;
    return it;
  endfunction

  // random tick: mostly fresh commands when idle, mostly plain ticks while busy,
  // with stray commands and unused kinds sprinkled in as noise
  function automatic in_item_t random_tick();
    in_item_t it;
    int       r;
    it.tx_byte     = 8'($urandom);
    it.ack_to_send = 1'($urandom);
    it.sda_in      = 1'($urandom);
    r = $urandom_range(0, 99);
    if (tracker.busy()) begin
      if (r < 84) it.kind = KIND_TICK;
      else if (r < 92) it.kind = 3'($urandom_range(int'(KIND_START), int'(KIND_READ)));
      else it.kind = 3'($urandom_range(int'(KIND_READ) + 1, 7));
    end else begin
      if (r < 10) it.kind = KIND_TICK;
      else if (r < 18) it.kind = 3'($urandom_range(int'(KIND_READ) + 1, 7));
      else if (r < 34) it.kind = KIND_START;
      else if (r < 50) it.kind = KIND_STOP;
      else if (r < 75) it.kind = KIND_WRITE;
      else it.kind = KIND_READ;
    end
    return it;
  endfunction

  // offers one beat and holds it until taken; between bursts valid drops for a gap unless the receiver is held off
  task automatic send_beat(input in_item_t it);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    tracker.note_tick(it);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 12);
      // keep offering while the receiver is held off so the engine backs up
      if (!hold_active) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  endtask

  // lets a running command run out
  task automatic run_until_idle();
    while (tracker.busy()) send_beat(random_tick());
  endtask

  // stops offering, waits for every due beat, then waits out a margin for the registered output
  task automatic park();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_quantum(input logic [DIV_WIDTH-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tracker.set_quantum(value);
  endtask

  // result side: compare every beat taken from the engine
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      tracker.check_levels(out_data);
    end
  end

  // watchdog: any beat on any port resets the count
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("watchdog: no beat for %0d cycles, %0d results due", STALL_LIMIT,
                 tracker.pending());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // receiver: stall pattern changes mode at random intervals, and once
  // holds off for a long stretch on request
  initial begin : receiver
    int mode;
    int left;
    int pat;
    mode = 0;
    left = 0;
    pat  = 0;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_req && !hold_active) begin
        hold_active = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req    = 1'b0;
        hold_active = 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(16, 80);
        end
        left--;
        pat++;
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 9) < 6);
          default: out_stall <= ((pat % 5) < 2);
        endcase
      end
    end
  end

  // main stimulus
  initial begin : stimulus
    logic [DIV_WIDTH-1:0] settings[6];
    in_item_t             it;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // a stop at the reset quantum, before any register write
    send_beat(tick_of(KIND_STOP, 8'h00, 1'b0, 1'b0));
    run_until_idle();
    park();

    // directed part with quantum zero, which behaves as one
    write_quantum('0);
    // unused kinds while idle, field extremes
    send_beat(tick_of(3'd5, 8'hff, 1'b1, 1'b1));
    send_beat(tick_of(3'd6, 8'h00, 1'b0, 1'b0));
    send_beat(tick_of(3'd7, 8'h80, 1'b1, 1'b0));
    // start; an unused kind while busy is not flagged, a command is
    send_beat(tick_of(KIND_START, 8'h00, 1'b0, 1'b0));
    send_beat(tick_of(3'd5, 8'hff, 1'b1, 1'b1));
    send_beat(tick_of(KIND_READ, 8'hff, 1'b1, 1'b1));
    // command on the very beat the start finishes: still rejected
    send_beat(tick_of(KIND_STOP, 8'h01, 1'b0, 1'b1));
    send_beat(tick_of(KIND_STOP, 8'h00, 1'b0, 1'b0));
    send_beat(tick_of(KIND_TICK, 8'h00, 1'b0, 1'b0));
    // read with nack, all ones on the bus; sda holds until the ack phase
    send_beat(tick_of(KIND_READ, 8'h00, 1'b1, 1'b0));
    while (tracker.busy()) send_beat(tick_of(KIND_TICK, 8'h00, 1'b0, 1'b1));
    park();

    // random part across several quantum settings, extremes included
    settings[0] = DIV_WIDTH'(1);
    settings[1] = DIV_WIDTH'(2);
    settings[2] = '0;
    settings[3] = DIV_WIDTH'(3);
    settings[4] = DIV_WIDTH'($urandom_range(4, 9));
    settings[5] = DIV_WIDTH'(1);
    foreach (settings[s]) begin
      write_quantum(settings[s]);
      // first setting carries the long receiver hold-off
      if (s == 0) hold_req = 1'b1;
      repeat (RANDOM_BEATS) send_beat(random_tick());
      run_until_idle();
      park();
    end

    // largest quantum: idle ticks only, one phase at this setting would
    // outlast the whole run
    write_quantum({DIV_WIDTH{1'b1}});
    it = random_tick();
    it.kind = KIND_TICK;
    send_beat(it);
    send_beat(tick_of(3'd6, 8'h5a, 1'b1, 1'b1));
    park();

    repeat (5) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
